>>> hdl/ffe_pkg.sv
`timescale 1ns / 1ps
package ffe_pkg;

	localparam int MAX_PAIRS_DEF = 64;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] PAIRS_RESET = 7'd8;
	localparam int FEAT_W = 6;
	localparam int FREQ_W = 24;
	localparam int COORD_W = 17;
	localparam int PHASE_W = 28;
	localparam int STEPS = 20;
	localparam int VW = 33;
	localparam int ZW = 28;
	localparam int CORDIC_START = 652032875;
	localparam logic OPC_LOAD = 1'b0;
	localparam logic OPC_ENCODE = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_ISSUE
	} ffe_state_t;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} ffe_quad_t;

	typedef struct packed {
		logic [FEAT_W-1:0] feature_index;
		logic last;
	} ffe_tag_t;

	function automatic logic signed [ZW-1:0] atan_turn(input int i);
		case (i)
			0: return ZW'(33554432);
			1: return ZW'(19808338);
			2: return ZW'(10466182);
			3: return ZW'(5312797);
			4: return ZW'(2666708);
			5: return ZW'(1334654);
			6: return ZW'(667490);
			7: return ZW'(333765);
			8: return ZW'(166885);
			9: return ZW'(83443);
			10: return ZW'(41722);
			11: return ZW'(20861);
			12: return ZW'(10430);
			13: return ZW'(5215);
			14: return ZW'(2608);
			15: return ZW'(1304);
			16: return ZW'(652);
			17: return ZW'(326);
			18: return ZW'(163);
			19: return ZW'(81);
			default: return '0;
		endcase
	endfunction

endpackage

>>> hdl/ffe_cordic.sv
`timescale 1ns / 1ps
module ffe_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [ffe_pkg::PHASE_W-1:0]      in_phase,
	input  ffe_pkg::ffe_tag_t                in_tag,
	output logic                             out_valid,
	output logic signed [15:0]               out_cos,
	output logic signed [15:0]               out_sin,
	output ffe_pkg::ffe_tag_t                out_tag
);

	localparam int VW = ffe_pkg::VW;
	localparam int ZW = ffe_pkg::ZW;
	localparam int STEPS = ffe_pkg::STEPS;
	localparam logic signed [VW-1:0] RND = VW'(16384);
	localparam logic signed [VW-1:0] POS_MAX = VW'(32767);
	localparam logic signed [VW-1:0] NEG_MIN = -VW'(32768);

	logic                    vld_q  [0:STEPS];
	logic signed [VW-1:0]    x_q    [0:STEPS];
	logic signed [VW-1:0]    y_q    [0:STEPS];
	logic signed [ZW-1:0]    z_q    [0:STEPS];
	ffe_pkg::ffe_quad_t      quad_q [0:STEPS];
	ffe_pkg::ffe_tag_t       tag_q  [0:STEPS];

	logic                    out_valid_q;
	logic signed [15:0]      cos_q;
	logic signed [15:0]      sin_q;
	ffe_pkg::ffe_tag_t       out_tag_q;

	logic signed [VW-1:0]    c_raw;
	logic signed [VW-1:0]    s_raw;

	function automatic logic signed [15:0] to_q15(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] t;
		t = (v + RND) >>> 15;
		if (t > POS_MAX) begin
			return 16'sh7fff;
		end else if (t < NEG_MIN) begin
			return -16'sh8000;
		end
		return 16'(t);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]    <= VW'(ffe_pkg::CORDIC_START);
			y_q[0]    <= '0;
			z_q[0]    <= $signed({2'b00, in_phase[25:0]});
			quad_q[0] <= ffe_pkg::ffe_quad_t'(in_phase[27:26]);
			tag_q[0]  <= in_tag;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [ZW-1:0] AT = ffe_pkg::atan_turn(i);
		logic signed [VW-1:0] dx;
		logic signed [VW-1:0] dy;

		assign dx = y_q[i] >>> i;
		assign dy = x_q[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (en) begin
				vld_q[i+1] <= vld_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][ZW-1]) begin
					x_q[i+1] <= x_q[i] - dx;
					y_q[i+1] <= y_q[i] + dy;
					z_q[i+1] <= z_q[i] - AT;
				end else begin
					x_q[i+1] <= x_q[i] + dx;
					y_q[i+1] <= y_q[i] - dy;
					z_q[i+1] <= z_q[i] + AT;
				end
				quad_q[i+1] <= quad_q[i];
				tag_q[i+1]  <= tag_q[i];
			end
		end
	end

	always_comb begin
		case (quad_q[STEPS])
			ffe_pkg::QUAD_0: begin
				c_raw = x_q[STEPS];
				s_raw = y_q[STEPS];
			end
			ffe_pkg::QUAD_90: begin
				c_raw = -y_q[STEPS];
				s_raw = x_q[STEPS];
			end
			ffe_pkg::QUAD_180: begin
				c_raw = -x_q[STEPS];
				s_raw = -y_q[STEPS];
			end
			default: begin
				c_raw = y_q[STEPS];
				s_raw = -x_q[STEPS];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q     <= to_q15(c_raw);
			sin_q     <= to_q15(s_raw);
			out_tag_q <= tag_q[STEPS];
		end
	end

	assign out_valid = out_valid_q;
	assign out_cos   = cos_q;
	assign out_sin   = sin_q;
	assign out_tag   = out_tag_q;

endmodule

>>> hdl/fourier_feature_encoder.sv
`timescale 1ns / 1ps
// an encode request passes the table read and phase product registers and the CORDIC
// input, step and output registers and yields one result per cycle; an encode blocks the
// input until its pairs are read, a load does not; the single read port of the frequency
// table gives one pair per cycle; output stalls freeze all the pipeline and the table read
// reset: asynchronous, clears control and valid state, pairs in use returns to 8;
// the frequency table is not cleared and is undefined until loaded
module fourier_feature_encoder #(
	parameter int MAX_PAIRS = ffe_pkg::MAX_PAIRS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ffe_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// entry_index, freq_x, freq_y, coord_x, coord_y
	input  logic [87:0]               s_tdata,
	// opcode
	input  logic                      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// feature_index, cos_value, sin_value, zero pad
	output logic [39:0]               m_tdata,
	output logic                      m_tlast
);

	localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int CNT_W = $clog2(MAX_PAIRS + 1);
	localparam int FW = ffe_pkg::FREQ_W;
	localparam int CW = ffe_pkg::COORD_W;
	localparam int PW = ffe_pkg::PHASE_W;

	logic [5:0]             entry_index;
	logic signed [FW-1:0]   freq_x;
	logic signed [FW-1:0]   freq_y;
	logic [CW-1:0]          coord_x;
	logic [CW-1:0]          coord_y;
	logic                   opcode;

	assign entry_index = s_tdata[5:0];
	assign freq_x      = s_tdata[29:6];
	assign freq_y      = s_tdata[53:30];
	assign coord_x     = s_tdata[70:54];
	assign coord_y     = s_tdata[87:71];
	assign opcode      = s_tuser;

	logic [ffe_pkg::CFG_W-1:0] pairs_q;
	logic [CNT_W-1:0]          n_eff;
	logic [CNT_W-1:0]          n_q;
	logic [IDX_W-1:0]          k_q;
	logic [CW-1:0]             cx_q;
	logic [CW-1:0]             cy_q;
	ffe_pkg::ffe_state_t       state_q;
	ffe_pkg::ffe_state_t       state_d;

	logic                      acc;
	logic                      ld_en;
	logic                      rd_en;
	logic                      adv;
	logic                      last_issue;

	logic [2*FW-1:0]           mem [MAX_PAIRS];
	logic [2*FW-1:0]           rd_s1;
	logic                      vld_s1;
	logic [CW-1:0]             cx_s1;
	logic [CW-1:0]             cy_s1;
	ffe_pkg::ffe_tag_t         tag_s1;
	logic                      vld_s2;
	logic [PW-1:0]             px_s2;
	logic [PW-1:0]             py_s2;
	ffe_pkg::ffe_tag_t         tag_s2;

	logic signed [FW-1:0]      fx_s1;
	logic signed [FW-1:0]      fy_s1;
	logic signed [FW+CW:0]     prod_x;
	logic signed [FW+CW:0]     prod_y;

	logic                      c_valid;
	logic signed [15:0]        c_cos;
	logic signed [15:0]        c_sin;
	ffe_pkg::ffe_tag_t         c_tag;

	assign acc   = s_tvalid && s_tready;
	assign ld_en = acc && (opcode == ffe_pkg::OPC_LOAD) &&
		({1'b0, entry_index} < 7'(MAX_PAIRS));
	assign adv   = !c_valid || m_tready;
	assign last_issue = (CNT_W'(k_q) + CNT_W'(1)) == n_q;

	always_comb begin
		if (pairs_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (pairs_q > 7'(MAX_PAIRS)) begin
			n_eff = CNT_W'(MAX_PAIRS);
		end else begin
			n_eff = CNT_W'(pairs_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= ffe_pkg::PAIRS_RESET;
		end else if (cfg_we) begin
			pairs_q <= cfg_wdata;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffe_pkg::ST_IDLE: begin
				if (acc && opcode == ffe_pkg::OPC_ENCODE) begin
					state_d = ffe_pkg::ST_ISSUE;
				end
			end
			ffe_pkg::ST_ISSUE: begin
				if (adv && last_issue) begin
					state_d = ffe_pkg::ST_IDLE;
				end
			end
			default: state_d = ffe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		case (state_q)
			ffe_pkg::ST_IDLE: s_tready = 1'b1;
			ffe_pkg::ST_ISSUE: rd_en = adv;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffe_pkg::ST_IDLE;
			k_q     <= '0;
			n_q     <= CNT_W'(1);
		end else begin
			state_q <= state_d;
			if (acc && opcode == ffe_pkg::OPC_ENCODE) begin
				k_q <= '0;
				n_q <= n_eff;
			end else if (rd_en) begin
				k_q <= k_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && opcode == ffe_pkg::OPC_ENCODE) begin
			cx_q <= coord_x;
			cy_q <= coord_y;
		end
	end

	// table: fy in the upper half, fx in the lower half
	always_ff @(posedge clk) begin
		if (ld_en) begin
			mem[entry_index[IDX_W-1:0]] <= {freq_y, freq_x};
		end
		if (rd_en) begin
			rd_s1 <= mem[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cx_s1                <= cx_q;
			cy_s1                <= cy_q;
			tag_s1.feature_index <= ffe_pkg::FEAT_W'(k_q);
			tag_s1.last          <= last_issue;
		end
	end

	assign fx_s1  = rd_s1[FW-1:0];
	assign fy_s1  = rd_s1[2*FW-1:FW];
	assign prod_x = fx_s1 * $signed({1'b0, cx_s1});
	assign prod_y = fy_s1 * $signed({1'b0, cy_s1});

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2  <= prod_x[PW-1:0];
			py_s2  <= prod_y[PW-1:0];
			tag_s2 <= tag_s1;
		end
	end

	ffe_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.in_phase  (px_s2 + py_s2),
		.in_tag    (tag_s2),
		.out_valid (c_valid),
		.out_cos   (c_cos),
		.out_sin   (c_sin),
		.out_tag   (c_tag)
	);

	assign m_tvalid = c_valid;
	assign m_tdata  = {2'b00, c_sin, c_cos, c_tag.feature_index};
	assign m_tlast  = c_tag.last;

endmodule

>>> hdl/ffe_checker.sv
`timescale 1ns / 1ps
module ffe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// an encode request blocks the input while its pairs are read
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("input ready right after encode request");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:38] == 2'b00)
		else $error("output pad bits not zero");

	a_rst: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind fourier_feature_encoder ffe_checker u_ffe_checker (.*);
